FILE: design/awui_pkg.sv
// Shared types, constants and decode functions for the weight unquantize/infill block.
package awui_pkg;

   // Store geometry
   localparam int MAX_GRID_WEIGHTS = 144;
   localparam int PLANE_COUNT      = 2;
   localparam int STORE_DEPTH      = PLANE_COUNT * MAX_GRID_WEIGHTS;
   localparam int STORE_AW         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int WEIGHT_W         = 7;

   localparam logic       PLANE1_OK  = (PLANE_COUNT > 1);
   localparam logic [8:0] GRID_LIMIT = 9'(MAX_GRID_WEIGHTS);

   // Request command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Encoding kinds
   localparam logic [1:0] ENC_BITS  = 2'd0;
   localparam logic [1:0] ENC_TRIT  = 2'd1;
   localparam logic [1:0] ENC_QUINT = 2'd2;

   // Register indexes
   typedef enum logic [1:0] {
      REG_GRID_WIDTH,
      REG_GRID_HEIGHT,
      REG_BLOCK_WIDTH,
      REG_BLOCK_HEIGHT
   } csr_reg_type;

   localparam logic [3:0] SIZE_RESET = 4'd4;
   localparam logic [3:0] GRID_MIN   = 4'd2;
   localparam logic [3:0] GRID_MAX   = 4'd12;
   localparam logic [3:0] BLOCK_MIN  = 4'd4;
   localparam logic [3:0] BLOCK_MAX  = 4'd12;

   // Fixed-point rounding terms
   localparam logic [13:0] GRID_ROUND   = 14'd32;
   localparam logic [7:0]  FRAC_ROUND   = 8'd8;
   localparam logic [4:0]  WEIGHT_ONE   = 5'd16;
   localparam logic [10:0] RESULT_ROUND = 11'd8;
   localparam logic [10:0] ACC_MAX      = 11'd1024;
   localparam int          FIX_ONE      = 1024;

   // Texel-to-grid step per block size n: (1024 + n/2) / (n - 1)
   localparam logic [8:0] STEP_TABLE [16] = '{
      9'd0, 9'd0, 9'd0, 9'd0,
      9'((FIX_ONE + 4 / 2) / (4 - 1)),
      9'((FIX_ONE + 5 / 2) / (5 - 1)),
      9'((FIX_ONE + 6 / 2) / (6 - 1)),
      9'((FIX_ONE + 7 / 2) / (7 - 1)),
      9'((FIX_ONE + 8 / 2) / (8 - 1)),
      9'((FIX_ONE + 9 / 2) / (9 - 1)),
      9'((FIX_ONE + 10 / 2) / (10 - 1)),
      9'((FIX_ONE + 11 / 2) / (11 - 1)),
      9'((FIX_ONE + 12 / 2) / (12 - 1)),
      9'd0, 9'd0, 9'd0
   };

   localparam logic [5:0] TRIT_PLAIN  [3] = '{6'd0, 6'd32, 6'd63};
   localparam logic [5:0] QUINT_PLAIN [5] = '{6'd0, 6'd16, 6'd32, 6'd47, 6'd63};

   // Neighbor select for the four infill reads
   typedef enum logic [1:0] {
      NB_00,
      NB_01,
      NB_10,
      NB_11
   } nb_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       load_write;
      logic       map_pos;
      logic       map_wgt;
      logic       rd_issue;
      nb_sel_type rd_sel;
      logic       acc_clear;
      logic       acc_en;
      logic       out_load;
   } awui_cmd_type;

   function automatic logic [3:0] clamp4(logic [3:0] v, logic [3:0] lo, logic [3:0] hi);
      logic [3:0] r;
      r = (v < lo) ? lo : ((v > hi) ? hi : v);
      return r;
   endfunction

   function automatic logic [STORE_AW-1:0] store_addr(logic plane, logic [7:0] idx);
      logic [STORE_AW-1:0] r;
      r = plane ? STORE_AW'(MAX_GRID_WEIGHTS) + STORE_AW'(idx) : STORE_AW'(idx);
      return r;
   endfunction

   // Fill 6 bits by repeating the count-bit pattern from the top down
   function automatic logic [5:0] replicate6(logic [4:0] bits, logic [2:0] count);
      logic [5:0] r;
      case (count)
         3'd1:    r = {6{bits[0]}};
         3'd2:    r = {3{bits[1:0]}};
         3'd3:    r = {2{bits[2:0]}};
         3'd4:    r = {bits[3:0], bits[3:2]};
         3'd5:    r = {bits[4:0], bits[4]};
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic logic [WEIGHT_W-1:0] unquantize(logic [1:0] kind, logic [2:0] count_raw,
                                                      logic [4:0] bits_raw, logic [2:0] digit);
      logic [2:0] count;
      logic [4:0] bits;
      logic [6:0] a;
      logic [6:0] b;
      logic [5:0] c;
      logic [2:0] d;
      logic [8:0] prod;
      logic [6:0] mixed;
      logic [5:0] r;
      logic       direct;
      count  = (count_raw > 3'd5) ? 3'd5 : count_raw;
      bits   = bits_raw & ((5'd1 << count) - 5'd1);
      a      = bits[0] ? 7'h7F : 7'h00;
      b      = 7'd0;
      c      = 6'd0;
      d      = 3'd0;
      r      = 6'd0;
      direct = 1'b0;
      case (kind)
         ENC_BITS: begin
            r      = replicate6(bits, count);
            direct = 1'b1;
         end
         ENC_TRIT: begin
            d = (digit > 3'd2) ? 3'd2 : digit;
            case (count)
               3'd0: begin
                  r      = TRIT_PLAIN[d[1:0]];
                  direct = 1'b1;
               end
               3'd1: c = 6'd50;
               3'd2: begin
                  c = 6'd23;
                  b = {bits[1], 3'b000, bits[1], 1'b0, bits[1]};
               end
               3'd3: begin
                  c = 6'd11;
                  b = {bits[2:1], 3'b000, bits[2:1]};
               end
               default: c = 6'd0;
            endcase
         end
         ENC_QUINT: begin
            d = (digit > 3'd4) ? 3'd4 : digit;
            case (count)
               3'd0: begin
                  r      = QUINT_PLAIN[d];
                  direct = 1'b1;
               end
               3'd1: c = 6'd28;
               3'd2: begin
                  c = 6'd13;
                  b = {bits[1], 4'b0000, bits[1], 1'b0};
               end
               default: c = 6'd0;
            endcase
         end
         default: begin
            // unsupported kind: zero digit, zero multiplier, zero offset
            if (count == 3'd0) begin
               direct = 1'b1;
            end
         end
      endcase
      if (!direct) begin
         prod  = 9'(d) * 9'(c) + 9'(b);
         mixed = prod[6:0] ^ a;
         r     = {a[5], mixed[6:2]};
      end
      return (r > 6'd32) ? WEIGHT_W'(r) + WEIGHT_W'(1) : WEIGHT_W'(r);
   endfunction

endpackage

FILE: design/awui_ram.sv
// Generic single-write, single-read RAM with registered read data.
module awui_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/awui_dp.sv
// Datapath: unquantize and store weights, map texels to the grid, accumulate the infill.
module awui_dp import awui_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  awui_cmd_type        cmd,
   input  logic [3:0]          grid_width,
   input  logic [3:0]          grid_height,
   input  logic [3:0]          block_width,
   input  logic [3:0]          block_height,
   input  logic [7:0]          req_grid_index,
   input  logic                req_plane,
   input  logic [1:0]          req_encoding_kind,
   input  logic [2:0]          req_base_bit_count,
   input  logic [4:0]          req_base_bit_value,
   input  logic [2:0]          req_tq_digit,
   input  logic [3:0]          req_texel_s,
   input  logic [3:0]          req_texel_t,
   output logic [WEIGHT_W-1:0] rsp_texel_weight
);

   logic [3:0] gw_c, gh_c, bw_c, bh_c;
   logic [3:0] s_last, t_last, s_c, t_c;
   logic [12:0] ps_full, pt_full;
   logic [13:0] gs_full, gt_full;
   logic [7:0]  w11_full;
   logic [7:0]  v0_full;
   logic [3:0]  fs, ft, js, jt;
   logic [4:0]  w00, w01, w10, w11;
   logic [8:0]  nb_idx;
   logic [4:0]  nb_w;
   logic        in_store;
   logic [11:0] product;

   logic                plane_ff;
   logic [10:0]         ps_ff, pt_ff;
   logic [7:0]          gs_ff, gt_ff;
   logic [3:0]          w11_ff;
   logic [7:0]          v0_ff;
   logic                use_ff;
   logic [4:0]          wsel_ff;
   logic [10:0]         acc_ff;
   logic [10:0]         acc_round;
   logic [WEIGHT_W-1:0] result_ff;

   logic                wr_en;
   logic [STORE_AW-1:0] wr_addr;
   logic [WEIGHT_W-1:0] wr_data;
   logic                rd_en;
   logic [STORE_AW-1:0] rd_addr;
   logic [WEIGHT_W-1:0] rd_data;

   assign gw_c = clamp4(grid_width, GRID_MIN, GRID_MAX);
   assign gh_c = clamp4(grid_height, GRID_MIN, GRID_MAX);
   assign bw_c = clamp4(block_width, BLOCK_MIN, BLOCK_MAX);
   assign bh_c = clamp4(block_height, BLOCK_MIN, BLOCK_MAX);

   // Texel position times step, taken straight from the request
   assign s_last  = bw_c - 4'd1;
   assign t_last  = bh_c - 4'd1;
   assign s_c     = (req_texel_s > s_last) ? s_last : req_texel_s;
   assign t_c     = (req_texel_t > t_last) ? t_last : req_texel_t;
   assign ps_full = 13'(STEP_TABLE[bw_c]) * 13'(s_c);
   assign pt_full = 13'(STEP_TABLE[bh_c]) * 13'(t_c);

   // Grid position in 1/16 units
   assign gs_full = 14'(ps_ff) * 14'(gw_c - 4'd1) + GRID_ROUND;
   assign gt_full = 14'(pt_ff) * 14'(gh_c - 4'd1) + GRID_ROUND;

   assign fs = gs_ff[3:0];
   assign js = gs_ff[7:4];
   assign ft = gt_ff[3:0];
   assign jt = gt_ff[7:4];

   assign w11_full = 8'(fs) * 8'(ft) + FRAC_ROUND;
   assign v0_full  = 8'(jt) * 8'(gw_c) + 8'(js);

   assign w11 = 5'(w11_ff);
   assign w01 = 5'(fs) - w11;
   assign w10 = 5'(ft) - w11;
   assign w00 = WEIGHT_ONE - 5'(fs) - 5'(ft) + w11;

   always_comb begin
      case (cmd.rd_sel)
         NB_00: begin
            nb_idx = 9'(v0_ff);
            nb_w   = w00;
         end
         NB_01: begin
            nb_idx = 9'(v0_ff) + 9'd1;
            nb_w   = w01;
         end
         NB_10: begin
            nb_idx = 9'(v0_ff) + 9'(gw_c);
            nb_w   = w10;
         end
         default: begin
            nb_idx = 9'(v0_ff) + 9'(gw_c) + 9'd1;
            nb_w   = w11;
         end
      endcase
   end

   assign in_store = nb_idx < GRID_LIMIT;
   assign rd_en    = cmd.rd_issue;
   assign rd_addr  = in_store ? store_addr(plane_ff, nb_idx[7:0]) : '0;

   assign wr_en   = cmd.load_write && (9'(req_grid_index) < GRID_LIMIT)
                    && (!req_plane || PLANE1_OK);
   assign wr_addr = store_addr(req_plane, req_grid_index);
   assign wr_data = unquantize(req_encoding_kind, req_base_bit_count,
                               req_base_bit_value, req_tq_digit);

   // Skip neighbors with zero factor or outside the store
   assign product   = use_ff ? 12'(rd_data) * 12'(wsel_ff) : 12'd0;
   assign acc_round = acc_ff + RESULT_ROUND;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         plane_ff <= req_plane && PLANE1_OK;
         ps_ff    <= ps_full[10:0];
         pt_ff    <= pt_full[10:0];
      end
      if (cmd.map_pos) begin
         gs_ff <= gs_full[13:6];
         gt_ff <= gt_full[13:6];
      end
      if (cmd.map_wgt) begin
         w11_ff <= w11_full[7:4];
         v0_ff  <= v0_full;
      end
      if (cmd.rd_issue) begin
         use_ff  <= in_store && (nb_w != 5'd0);
         wsel_ff <= nb_w;
      end
      if (cmd.acc_clear) begin
         acc_ff <= 11'd0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + product[10:0];
      end
      if (cmd.out_load) begin
         result_ff <= acc_round[10:4];
      end
   end

   assign rsp_texel_weight = result_ff;

   awui_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> acc_ff <= ACC_MAX)
      else $error("infill sum above full weight");

   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_texel_weight <= 7'd64)
      else $error("texel weight out of range");

   a_write_addr: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> 32'(wr_addr) < STORE_DEPTH)
      else $error("store write address out of range");

   a_read_addr: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> 32'(rd_addr) < STORE_DEPTH)
      else $error("store read address out of range");

endmodule

FILE: design/awui_ctrl.sv
// Controller: request handshake, query sequencing and result register control.
module awui_ctrl import awui_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_command,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output awui_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_POS,
      S_WGT,
      S_RD0,
      S_RD1,
      S_RD2,
      S_RD3,
      S_LAST,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      cmd.rd_sel = NB_00;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_QUERY) begin
                  cmd.capture = 1'b1;
                  state_in    = S_POS;
               end else begin
                  cmd.load_write = 1'b1;
               end
            end
         end
         S_POS: begin
            cmd.map_pos = 1'b1;
            state_in    = S_WGT;
         end
         S_WGT: begin
            cmd.map_wgt = 1'b1;
            state_in    = S_RD0;
         end
         S_RD0: begin
            cmd.rd_issue  = 1'b1;
            cmd.rd_sel    = NB_00;
            cmd.acc_clear = 1'b1;
            state_in      = S_RD1;
         end
         S_RD1: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_sel   = NB_01;
            cmd.acc_en   = 1'b1;
            state_in     = S_RD2;
         end
         S_RD2: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_sel   = NB_10;
            cmd.acc_en   = 1'b1;
            state_in     = S_RD3;
         end
         S_RD3: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_sel   = NB_11;
            cmd.acc_en   = 1'b1;
            state_in     = S_LAST;
         end
         S_LAST: begin
            cmd.acc_en = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_LOAD) |=> state_ff == S_IDLE)
      else $error("load request left idle");

   a_query_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_QUERY) |-> ##8 state_ff == S_OUT)
      else $error("query sequence length wrong");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("response raised outside result stage");

   a_acc_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.acc_clear && cmd.acc_en))
      else $error("accumulator cleared and advanced together");

endmodule

FILE: design/astc_weight_unquantize_infill.sv
// Top level: weight store unquantize on load, bilinear weight infill on query.
//
// Requests arrive on req_* (valid/ready). req_command selects a load, which
// unquantizes one trit, quint or plain-bit weight to 0..64 and writes it into
// the weight store at (req_plane, req_grid_index), or a query, which returns
// the infilled weight of texel (req_texel_s, req_texel_t) on rsp_texel_weight.
// Loads produce no response and are taken one per cycle while no query is
// in progress; the write happens at the accept edge. A query holds the request
// port from its accept edge through grid mapping, four reads of the weight
// store, a drain of the last read and the load of the result register, so no
// new request is taken mid-query. rsp_valid rises as the result register loads.
// The result register parts the two sides: while a response waits, the next
// request is accepted and worked on, and a query only holds in its final stage
// until the waiting response is taken.
// Grid and block sizes come from the csr_* write port and must only be
// changed while the block is idle. Reset clears the controller, drops
// rsp_valid and sets all sizes to 4; store entries are undefined until loaded.
module astc_weight_unquantize_infill import awui_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [7:0]          req_grid_index,
   input  logic                req_plane,
   input  logic [1:0]          req_encoding_kind,
   input  logic [2:0]          req_base_bit_count,
   input  logic [4:0]          req_base_bit_value,
   input  logic [2:0]          req_tq_digit,
   input  logic [3:0]          req_texel_s,
   input  logic [3:0]          req_texel_t,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WEIGHT_W-1:0] rsp_texel_weight,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [3:0]          csr_write_data
);

   logic [3:0]   grid_width_ff, grid_height_ff, block_width_ff, block_height_ff;
   awui_cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= SIZE_RESET;
         grid_height_ff  <= SIZE_RESET;
         block_width_ff  <= SIZE_RESET;
         block_height_ff <= SIZE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_reg_type'(csr_index))
            REG_GRID_WIDTH:   grid_width_ff   <= csr_write_data;
            REG_GRID_HEIGHT:  grid_height_ff  <= csr_write_data;
            REG_BLOCK_WIDTH:  block_width_ff  <= csr_write_data;
            REG_BLOCK_HEIGHT: block_height_ff <= csr_write_data;
         endcase
      end
   end

   awui_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd)
   );

   awui_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .grid_width         (grid_width_ff),
      .grid_height        (grid_height_ff),
      .block_width        (block_width_ff),
      .block_height       (block_height_ff),
      .req_grid_index     (req_grid_index),
      .req_plane          (req_plane),
      .req_encoding_kind  (req_encoding_kind),
      .req_base_bit_count (req_base_bit_count),
      .req_base_bit_value (req_base_bit_value),
      .req_tq_digit       (req_tq_digit),
      .req_texel_s        (req_texel_s),
      .req_texel_t        (req_texel_t),
      .rsp_texel_weight   (rsp_texel_weight)
   );

endmodule
